@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// shared constants, types and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int POOL_ORDER_DEF    = 20;
  localparam int MIN_ORDER_DEF     = 7;
  localparam int MAX_REQ_BYTES_DEF = 131072;
  localparam int HDR_BYTES         = 32;
  localparam int REQ_W             = 18;
  localparam int ADDR_W            = 20;
  localparam int STATUS_W          = 2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_POP_WAIT,
    S_SPLIT,
    S_WALK_RD,
    S_WALK_WAIT,
    S_UNLINK,
    S_PUSH,
    S_DONE
  } state_t;

  // bit length of v, i.e. ceil log2 of v+1
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 6'(i + 1);
    end
    return p;
  endfunction

endpackage

@@ rtl/bba_link_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_link_mem
// link memory, one next-slot entry per minimum block, registered read
// ----------------------------------------------------------------------------
module bba_link_mem #(
  parameter int SLOT_W = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [SLOT_W:0]   wdata,
  input  logic [SLOT_W-1:0] raddr,
  output logic [SLOT_W:0]   rdata
);

  logic [SLOT_W:0] mem [2**SLOT_W];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/buddy_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// binary buddy allocator with per-order lifo free lists in a link memory
// ----------------------------------------------------------------------------
// sequence: alloc scans orders, pops and splits down to the target; a range
//   error goes straight to the strobe; free walks lists then pushes, full pool pushes
// throughput: one transaction at a time, busy high until the result strobe,
//   next accept the cycle after it; the walk through the link memory sets pace
// reset: synchronous active low, heads cleared except the top order; link
//   memory has no reset; the receiver cannot stall, results last one cycle
module buddy_block_allocator_unit #(
  parameter int POOL_ORDER    = bba_pkg::POOL_ORDER_DEF,
  parameter int MIN_ORDER     = bba_pkg::MIN_ORDER_DEF,
  parameter int MAX_REQ_BYTES = bba_pkg::MAX_REQ_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_op,
  input  logic [bba_pkg::REQ_W-1:0]     in_req_size,
  input  logic [bba_pkg::ADDR_W-1:0]    in_block_addr,
  output logic                          out_valid,
  output logic [bba_pkg::ADDR_W-1:0]    out_addr,
  output logic [bba_pkg::STATUS_W-1:0]  out_status
);

  localparam int SLOT_W  = POOL_ORDER - MIN_ORDER;
  localparam int NORD    = SLOT_W + 1;
  localparam int ORD_W   = $clog2(NORD + 1);
  localparam int STEP_W  = SLOT_W + 1;

  // head per order: slot + 1, zero = empty
  logic [SLOT_W:0]  heads_r [NORD];
  logic [SLOT_W:0]  heads_nxt [NORD];

  bba_pkg::state_t  state_r, state_nxt;
  logic [ORD_W-1:0] need_r, need_nxt;   // target order index
  logic [ORD_W-1:0] k_r, k_nxt;         // current order index
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W:0]  cur_r, cur_nxt;     // list walk position, slot + 1
  logic [SLOT_W:0]  prev_r, prev_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [bba_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [bba_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  logic [SLOT_W:0]   mem_wdata, mem_rdata;

  bba_link_mem #(.SLOT_W(SLOT_W)) u_links (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // request decode
  logic [5:0]  a_ord, f_ord;
  logic [31:0] a_sum, f_m1;
  always_comb begin
    a_sum = 32'(in_req_size) + 32'(bba_pkg::HDR_BYTES) - 32'd1;
    a_ord = bba_pkg::bit_len(a_sum);
    if (a_ord < 6'(MIN_ORDER)) a_ord = 6'(MIN_ORDER);
    f_m1  = (in_req_size == '0) ? 32'd0 : 32'(in_req_size) - 32'd1;
    f_ord = bba_pkg::bit_len(f_m1);
    if (f_ord < 6'(MIN_ORDER)) f_ord = 6'(MIN_ORDER);
  end

  logic [SLOT_W-1:0] in_slot, bud;
  logic [SLOT_W:0]   one_k;
  always_comb begin
    in_slot = SLOT_W'(in_block_addr >> MIN_ORDER);
    one_k   = (SLOT_W+1)'(1) << k_r;
    bud     = slot_r ^ one_k[SLOT_W-1:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (start) begin
          if (in_op == bba_pkg::OP_ALLOC) begin
            if (32'(in_req_size) > 32'(MAX_REQ_BYTES) || a_ord > 6'(POOL_ORDER))
              state_nxt = bba_pkg::S_DONE;
            else
              state_nxt = bba_pkg::S_SCAN;
          end else begin
            if (f_ord > 6'(POOL_ORDER)) state_nxt = bba_pkg::S_DONE;
            else if (f_ord == 6'(POOL_ORDER)) state_nxt = bba_pkg::S_PUSH;
            else state_nxt = bba_pkg::S_WALK_RD;
          end
        end
      end
      bba_pkg::S_SCAN: begin
        if (k_r > ORD_W'(SLOT_W)) state_nxt = bba_pkg::S_DONE;
        else if (heads_r[k_r[ORD_W-1:0]] != '0) state_nxt = bba_pkg::S_POP_RD;
      end
      bba_pkg::S_POP_RD:   state_nxt = bba_pkg::S_POP_WAIT;
      bba_pkg::S_POP_WAIT: state_nxt = (k_r == need_r) ? bba_pkg::S_DONE : bba_pkg::S_SPLIT;
      bba_pkg::S_SPLIT:    if (k_r == need_r + 1'b1) state_nxt = bba_pkg::S_DONE;
      bba_pkg::S_WALK_RD: begin
        if (cur_r == '0 || steps_r[SLOT_W]) state_nxt = bba_pkg::S_PUSH;
        else if (cur_r[SLOT_W:0] - 1'b1 == {1'b0, bud}) state_nxt = bba_pkg::S_UNLINK;
        else state_nxt = bba_pkg::S_WALK_WAIT;
      end
      bba_pkg::S_WALK_WAIT: state_nxt = bba_pkg::S_WALK_RD;
      bba_pkg::S_UNLINK: begin
        if (k_r + 1'b1 == ORD_W'(SLOT_W)) state_nxt = bba_pkg::S_PUSH;
        else state_nxt = bba_pkg::S_WALK_RD;
      end
      bba_pkg::S_PUSH: state_nxt = bba_pkg::S_DONE;
      bba_pkg::S_DONE: state_nxt = bba_pkg::S_IDLE;
      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    heads_nxt  = heads_r;
    need_nxt   = need_r;
    k_nxt      = k_r;
    slot_nxt   = slot_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    steps_nxt  = steps_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = slot_r;
    mem_wdata  = '0;
    mem_raddr  = slot_r;
    case (state_r)
      bba_pkg::S_IDLE: begin
        if (start) begin
          addr_nxt   = '0;
          status_nxt = bba_pkg::ST_OK;
          if (in_op == bba_pkg::OP_ALLOC) begin
            need_nxt = ORD_W'(a_ord - 6'(MIN_ORDER));
            k_nxt    = ORD_W'(a_ord - 6'(MIN_ORDER));
            if (32'(in_req_size) > 32'(MAX_REQ_BYTES) || a_ord > 6'(POOL_ORDER))
              status_nxt = bba_pkg::ST_RANGE;
          end else begin
            k_nxt     = ORD_W'(f_ord - 6'(MIN_ORDER));
            slot_nxt  = in_slot & ~SLOT_W'((({{SLOT_W{1'b0}}, 1'b1}) <<
                        (f_ord - 6'(MIN_ORDER))) - 1'b1);
            cur_nxt   = heads_r[ORD_W'(f_ord - 6'(MIN_ORDER))];
            prev_nxt  = '0;
            steps_nxt = '0;
            if (f_ord > 6'(POOL_ORDER)) status_nxt = bba_pkg::ST_RANGE;
          end
        end
      end
      bba_pkg::S_SCAN: begin
        if (k_r > ORD_W'(SLOT_W)) status_nxt = bba_pkg::ST_NOMEM;
        else if (heads_r[k_r] != '0) slot_nxt = SLOT_W'(heads_r[k_r] - 1'b1);
        else k_nxt = k_r + 1'b1;
      end
      bba_pkg::S_POP_RD: mem_raddr = slot_r;
      bba_pkg::S_POP_WAIT: begin
        heads_nxt[k_r] = mem_rdata;
        addr_nxt = bba_pkg::ADDR_W'({slot_r, {MIN_ORDER{1'b0}}});
      end
      bba_pkg::S_SPLIT: begin
        // push upper half one order down
        k_nxt     = k_r - 1'b1;
        mem_we    = 1'b1;
        mem_waddr = slot_r + SLOT_W'((SLOT_W+1)'(1) << (k_r - 1'b1));
        mem_wdata = heads_r[k_r - 1'b1];
        heads_nxt[k_r - 1'b1] = {1'b0, mem_waddr} + 1'b1;
      end
      bba_pkg::S_WALK_RD: begin
        mem_raddr = SLOT_W'(cur_r - 1'b1);
        if (!(cur_r == '0 || steps_r[SLOT_W]) &&
            cur_r - 1'b1 == {1'b0, bud}) begin
          // read of the buddy link underway
        end
      end
      bba_pkg::S_WALK_WAIT: begin
        prev_nxt  = cur_r;
        cur_nxt   = mem_rdata;
        steps_nxt = steps_r + 1'b1;
      end
      bba_pkg::S_UNLINK: begin
        if (prev_r == '0) heads_nxt[k_r] = mem_rdata;
        else begin
          mem_we    = 1'b1;
          mem_waddr = SLOT_W'(prev_r - 1'b1);
          mem_wdata = mem_rdata;
        end
        if (bud < slot_r) slot_nxt = bud;
        k_nxt     = k_r + 1'b1;
        cur_nxt   = (k_r + 1'b1 == ORD_W'(SLOT_W)) ? '0 : heads_r[k_r + 1'b1];
        if (prev_r == '0 && k_r + 1'b1 != ORD_W'(SLOT_W)) cur_nxt = heads_r[k_r + 1'b1];
        prev_nxt  = '0;
        steps_nxt = '0;
      end
      bba_pkg::S_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = heads_r[k_r];
        heads_nxt[k_r] = {1'b0, slot_r} + 1'b1;
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy       = (state_r != bba_pkg::S_IDLE);
    out_valid  = (state_r == bba_pkg::S_DONE);
    out_addr   = addr_r;
    out_status = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_IDLE;
      // only the full pool is free after reset
      for (int i = 0; i < NORD; i++) heads_r[i] <= (SLOT_W+1)'(i == NORD - 1);
    end else begin
      state_r <= state_nxt;
      heads_r <= heads_nxt;
    end
    need_r   <= need_nxt;
    k_r      <= k_nxt;
    slot_r   <= slot_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    steps_r  <= steps_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the buddy block allocator: a scoreboard carries its
// own copy of the free lists, predicts every grant and status, and compares
// each strobed result; the stimulus keeps a table of granted blocks so that
// most frees return real blocks and drive merges all the way up the orders
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  localparam int POOL_ORD  = 20;
  localparam int MIN_ORD   = 7;
  localparam int MAX_REQ   = 131072;
  localparam int N_ORD     = POOL_ORD - MIN_ORD + 1;
  localparam int N_SLOT    = 1 << (POOL_ORD - MIN_ORD);
  localparam int N_ITEMS   = 1450;
  localparam int CYC_LIMIT = 4000000;

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    logic [STATUS_W-1:0] status;
  } grant_t;

  // free-list mirror plus the queue of results still owed by the block
  class alloc_scoreboard;
    bit [13:0] heads[N_ORD];
    bit [13:0] links[N_SLOT];
    grant_t    owed[$];
    int        n_bad;
    int        n_checked;

    function new();
      foreach (heads[i]) heads[i] = '0;
      foreach (links[i]) links[i] = '0;
      heads[N_ORD-1] = 14'd1;
    endfunction

    function int clog2_of(int v);
      int p;
      int x;
      p = 0;
      x = v - 1;
      while (x != 0) begin
        p++;
        x = x >> 1;
      end
      return p;
    endfunction

    function void push_free(int ord, int slot);
      links[slot & (N_SLOT-1)] = heads[ord-MIN_ORD];
      heads[ord-MIN_ORD] = 14'((slot & (N_SLOT-1)) + 1);
    endfunction

    // pull the buddy out of its list; walks are bounded in case of loops
    function bit unlink_buddy(int ord, int slot);
      int cur;
      int prev;
      int steps;
      int cs;
      cur = heads[ord-MIN_ORD];
      prev = 0;
      steps = 0;
      while (cur != 0 && steps < N_SLOT) begin
        cs = (cur - 1) & (N_SLOT-1);
        if (cs == slot) begin
          if (prev == 0) heads[ord-MIN_ORD] = links[cs];
          else links[(prev-1) & (N_SLOT-1)] = links[cs];
          return 1'b1;
        end
        prev = cur;
        cur = links[cs];
        steps++;
      end
      return 1'b0;
    endfunction

    function void note_input(logic op, int size, int baddr, output grant_t g);
      int ord;
      int k;
      int slot;
      int bud;
      g.addr = '0;
      g.status = ST_OK;
      if (op == OP_ALLOC) begin
        ord = clog2_of(size + HDR_BYTES);
        if (ord < MIN_ORD) ord = MIN_ORD;
        if (size > MAX_REQ || ord > POOL_ORD) g.status = ST_RANGE;
        else begin
          k = ord;
          while (k <= POOL_ORD && heads[k-MIN_ORD] == 0) k++;
          if (k > POOL_ORD) g.status = ST_NOMEM;
          else begin
            slot = (heads[k-MIN_ORD] - 1) & (N_SLOT-1);
            heads[k-MIN_ORD] = links[slot];
            // keep lower halves, upper buddies go one order down
            while (k > ord) begin
              k--;
              push_free(k, slot + (1 << (k - MIN_ORD)));
            end
            g.addr = ADDR_W'(slot << MIN_ORD);
          end
        end
      end else begin
        ord = clog2_of(size == 0 ? 1 : size);
        if (ord < MIN_ORD) ord = MIN_ORD;
        if (ord > POOL_ORD) g.status = ST_RANGE;
        else begin
          slot = (baddr >> MIN_ORD) & (N_SLOT-1);
          slot = slot & ~((1 << (ord - MIN_ORD)) - 1);
          while (ord < POOL_ORD) begin
            bud = slot ^ (1 << (ord - MIN_ORD));
            if (!unlink_buddy(ord, bud)) break;
            if (bud < slot) slot = bud;
            ord++;
          end
          push_free(ord, slot);
        end
      end
      owed.push_back(g);
    endfunction

    function void check_result(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status);
      grant_t e;
      if (owed.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result: addr %h status %0d", addr, status);
        return;
      end
      e = owed.pop_front();
      n_checked++;
      if (addr !== e.addr || status !== e.status) begin
        n_bad++;
        if (n_bad <= 10)
          $display("result %0d: expected addr %h status %0d, got addr %h status %0d",
                   n_checked, e.addr, e.status, addr, status);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_op;
  logic [REQ_W-1:0]    in_req_size;
  logic [ADDR_W-1:0]   in_block_addr;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_addr;
  logic [STATUS_W-1:0] out_status;

  buddy_block_allocator_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_req_size  (in_req_size),
    .in_block_addr(in_block_addr),
    .out_valid    (out_valid),
    .out_addr     (out_addr),
    .out_status   (out_status)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  alloc_scoreboard sb;

  // blocks currently held by the stimulus side
  int live_addr[$];
  int live_ord[$];
  int n_alloc, n_free, n_nomem, n_range;
  int burst_left;
  int cycles;

  // results are stable mid-cycle; sampling on the falling edge avoids races
  always @(negedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_addr, out_status);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one transaction: present it, hold until accepted, then note it; returns at
  // the accepting edge so the caller can chain the next one without a drop
  task automatic send_txn(logic op, int size, int baddr);
    grant_t g;
    int o;
    int dup;
    in_op         <= op;
    in_req_size   <= REQ_W'(size);
    in_block_addr <= ADDR_W'(baddr);
    start         <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    sb.note_input(op, size, baddr, g);
    if (op == OP_FREE) n_free++;
    else begin
      n_alloc++;
      if (g.status == ST_NOMEM) n_nomem++;
      if (g.status == ST_RANGE) n_range++;
      if (g.status == ST_OK) begin
        o = sb.clog2_of(size + HDR_BYTES);
        if (o < MIN_ORD) o = MIN_ORD;
        dup = 0;
        foreach (live_addr[i]) if (live_addr[i] == int'(g.addr)) dup = 1;
        if (!dup) begin
          live_addr.push_back(int'(g.addr));
          live_ord.push_back(o);
        end
      end
    end
  endtask

  // sender pacing: bursts of back-to-back transactions, then a random gap
  task automatic pace();
    if (burst_left > 0) burst_left--;
    else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 6);
    end
  endtask

  task automatic alloc_rand();
    int o;
    int top;
    if ($urandom_range(0, 32) == 0) begin
      send_txn(OP_ALLOC, $urandom_range(MAX_REQ + 1, (1 << REQ_W) - 1), $urandom);
      return;
    end
    o = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 11 : 4);
    top = (1 << (o + MIN_ORD)) - HDR_BYTES;
    send_txn(OP_ALLOC, $urandom_range(0, top), $urandom);
  endtask

  // free a held block with any size recorded for its order and junk low bits
  task automatic free_live(int idx);
    int a;
    int o;
    int sz;
    a = live_addr[idx];
    o = live_ord[idx];
    live_addr.delete(idx);
    live_ord.delete(idx);
    sz = (o == MIN_ORD) ? $urandom_range(0, 1 << MIN_ORD)
                        : $urandom_range((1 << (o - 1)) + 1, 1 << o);
    send_txn(OP_FREE, sz, a + $urandom_range(0, (1 << o) - 1));
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_ALLOC;
    in_req_size = '0;
    in_block_addr = '0;
    cycles = 0;
    burst_left = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a minimum-size free first, so the first pop of the full pool
    // reads a link that has been written
    send_txn(OP_FREE, 100, 0);
    send_txn(OP_ALLOC, 0, 0);
    send_txn(OP_ALLOC, 96, 0);                 // exactly one minimum block
    send_txn(OP_ALLOC, 97, 0);                 // one byte over, next order
    send_txn(OP_ALLOC, MAX_REQ, 0);            // largest legal request
    send_txn(OP_ALLOC, MAX_REQ + 1, 0);        // just out of range
    send_txn(OP_ALLOC, (1 << REQ_W) - 1, 0);   // widest request field
    repeat (4) send_txn(OP_ALLOC, MAX_REQ, 0); // drain the pool until no memory
    send_txn(OP_ALLOC, 5, 0);
    // give everything back; the last merges reach the full pool
    while (live_addr.size() > 0) free_live($urandom_range(0, live_addr.size() - 1));
    send_txn(OP_ALLOC, 200000, 0);             // range error on an idle pool
    send_txn(OP_FREE, (1 << REQ_W) - 1, (1 << ADDR_W) - 1); // widest size field, an order-18 free
    send_txn(OP_ALLOC, 1000, 0);

    for (int i = 0; i < N_ITEMS; i++) begin
      pace();
      if (i >= N_ITEMS - 20 && $urandom_range(0, 1) == 0)
        // stray frees near the end may corrupt lists; walks stay bounded
        send_txn(OP_FREE, $urandom_range(0, (1 << REQ_W) - 1),
                 $urandom_range(0, (1 << ADDR_W) - 1));
      else if (live_addr.size() == 0 ||
               (live_addr.size() < 150 && $urandom_range(0, 99) < 55))
        alloc_rand();
      else
        free_live($urandom_range(0, live_addr.size() - 1));
    end
    start <= 1'b0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("covered %0d allocs (%0d out of memory, %0d out of range) and %0d frees",
             n_alloc, n_nomem, n_range, n_free);
    $display("%0d results compared, %0d mismatches", sb.n_checked, sb.n_bad);
    if (sb.n_bad == 0 && sb.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bba_pkg.sv
rtl/bba_link_mem.sv
rtl/buddy_block_allocator_unit.sv
bench/testbench.sv
